// File: hw/rtl/one_bit_edge_to_pcm_dc_blocked_top_assert.svh
// Assertion macros shared by the converter's modules.
`ifndef ONE_BIT_EDGE_TO_PCM_DC_BLOCKED_TOP_ASSERT_SVH
`define ONE_BIT_EDGE_TO_PCM_DC_BLOCKED_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBEPCM_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obepcm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OBEPCM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obepcm assertion failed");

`endif

// File: hw/rtl/obepcm_pkg.sv
package obepcm_pkg;

   // Fixed widths of the channel fields.
   localparam int PHASE_IN_W = 16;
   localparam int PCM_W      = 16;
   localparam int COEF_W     = 11;

   // Item codes carried in func.
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // High-pass pole in units of 1/1024.
   localparam int COEF_FRAC_BITS = 10;
   localparam logic [COEF_W-1:0] COEF_ONE   = 11'd1024;
   localparam logic [COEF_W-1:0] COEF_RESET = 11'd1008;
   localparam int COEF_HALF = 512;

   // Output full scale and the queue between front and back.
   localparam int PCM_SCALE_SHIFT = 15;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

endpackage

// File: hw/rtl/obepcm_if.sv
interface obepcm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic [obepcm_pkg::PHASE_IN_W-1:0]    event_phase;
   logic                                 new_level;

   modport source (output valid, func, event_phase, new_level, input ready);
   modport sink   (input valid, func, event_phase, new_level, output ready);
endinterface

interface obepcm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [obepcm_pkg::PCM_W-1:0]  pcm_sample;

   modport source (output valid, pcm_sample, input ready);
   modport sink   (input valid, pcm_sample, output ready);
endinterface

interface obepcm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [obepcm_pkg::COEF_W-1:0]        filter_coefficient;

   modport source (output valid, filter_coefficient, input ready);
   modport sink   (input valid, filter_coefficient, output ready);
endinterface

// File: hw/rtl/obepcm_front.sv
module obepcm_front #(
   parameter int PHASE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   obepcm_req_if.sink                    req_ch,
   input  logic                          queue_full,
   output logic                          push_valid,
   output logic signed [PHASE_BITS+2:0]  push_data
);

   localparam int SIG_W = PHASE_BITS + 3;

   logic                     drive_level_ff, drive_level_in;
   logic [PHASE_BITS-1:0]    phase_pos_ff, phase_pos_in;
   logic signed [SIG_W-1:0]  area_accum_ff, area_accum_in;

   logic                     accept;
   logic [PHASE_BITS-1:0]    evt_phase;
   logic signed [SIG_W-1:0]  step_area;
   logic signed [SIG_W-1:0]  rest_area;
   logic signed [SIG_W-1:0]  total;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      evt_phase = PHASE_BITS'(req_ch.event_phase);
      step_area = SIG_W'(evt_phase - phase_pos_ff);
      // The rest of the period runs from the current position up to 1.0.
      rest_area = SIG_W'({1'b1, {PHASE_BITS{1'b0}}} - {1'b0, phase_pos_ff});
      total     = drive_level_ff ? (area_accum_ff + rest_area)
                                 : (area_accum_ff - rest_area);
      push_data = total >>> 1;
      push_valid = accept && (req_ch.func == obepcm_pkg::FUNC_TICK);
   end

   always_comb begin
      drive_level_in = drive_level_ff;
      phase_pos_in   = phase_pos_ff;
      area_accum_in  = area_accum_ff;
      if (accept) begin
         if (req_ch.func == obepcm_pkg::FUNC_TICK) begin
            phase_pos_in  = '0;
            area_accum_in = '0;
         end else begin
            // An event at or before the current position adds no area.
            if (evt_phase > phase_pos_ff) begin
               area_accum_in = drive_level_ff ? (area_accum_ff + step_area)
                                              : (area_accum_ff - step_area);
               phase_pos_in  = evt_phase;
            end
            drive_level_in = req_ch.new_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_level_ff <= 1'b0;
         phase_pos_ff   <= '0;
         area_accum_ff  <= '0;
      end else begin
         drive_level_ff <= drive_level_in;
         phase_pos_ff   <= phase_pos_in;
         area_accum_ff  <= area_accum_in;
      end
   end

endmodule

// File: hw/rtl/obepcm_queue.sv
`include "one_bit_edge_to_pcm_dc_blocked_top_assert.svh"

module obepcm_queue #(
   parameter int DATA_W = 19
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  logic signed [DATA_W-1:0]  push_data,
   input  logic                      pop,
   output logic                      full,
   output logic                      empty,
   output logic signed [DATA_W-1:0]  head_data
);

   localparam int DEPTH = obepcm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = obepcm_pkg::QUEUE_PTR_W;

   logic signed [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]           count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push_valid && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `OBEPCM_ASSERT_SAME(a_no_push_when_full, clock, reset, push_valid, !full)
   `OBEPCM_ASSERT_SAME(a_no_pop_when_empty, clock, reset, pop, !empty)
   `OBEPCM_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= (PTR_W+1)'(DEPTH))

endmodule

// File: hw/rtl/obepcm_back.sv
`include "one_bit_edge_to_pcm_dc_blocked_top_assert.svh"

module obepcm_back #(
   parameter int PHASE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   obepcm_csr_if.sink                    csr_ch,
   obepcm_rsp_if.source                  rsp_ch,
   input  logic                          queue_empty,
   input  logic signed [PHASE_BITS+2:0]  queue_data,
   output logic                          pop
);

   localparam int SIG_W  = PHASE_BITS + 3;
   localparam int PROD_W = SIG_W + obepcm_pkg::COEF_W + 1;
   localparam int PCM_PW = SIG_W + obepcm_pkg::PCM_SCALE_SHIFT + 2;
   localparam int PCM_W  = obepcm_pkg::PCM_W;
   localparam logic signed [SIG_W-1:0] PREV_RESET =
      {{(SIG_W-PHASE_BITS+1){1'b1}}, {(PHASE_BITS-1){1'b0}}};

   logic [obepcm_pkg::COEF_W-1:0] coef_ff, coef_in;
   logic signed [SIG_W-1:0]       filter_out_ff, filter_out_in;
   logic signed [SIG_W-1:0]       prev_drive_ff, prev_drive_in;
   logic                          mid_valid_ff, mid_valid_in;
   logic signed [SIG_W-1:0]       mid_y_ff, mid_y_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [PCM_W-1:0]       out_pcm_ff, out_pcm_in;

   logic                          out_free;
   logic                          mid_move;
   logic [obepcm_pkg::COEF_W-1:0] coef_used;
   logic signed [PROD_W-1:0]      prod;
   logic signed [PROD_W-1:0]      x_ext;
   logic signed [PROD_W-1:0]      prev_ext;
   logic signed [PROD_W-1:0]      y_sum;
   logic signed [SIG_W-1:0]       y_new;
   logic signed [PCM_PW-1:0]      y_wide;
   logic signed [PCM_PW-1:0]      round_c;
   logic signed [PCM_PW-1:0]      pcm_wide;
   logic                          pcm_fits;

   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pcm_sample = out_pcm_ff;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign mid_move = mid_valid_ff && out_free;
   assign pop      = !queue_empty && (!mid_valid_ff || out_free);

   // Filter step: y = round(R * y_prev) + x - x_prev, held to the signal range.
   always_comb begin
      coef_used = (coef_ff > obepcm_pkg::COEF_ONE) ? obepcm_pkg::COEF_ONE : coef_ff;
      prod      = $signed({1'b0, coef_used}) * filter_out_ff;
      x_ext     = PROD_W'(queue_data);
      prev_ext  = PROD_W'(prev_drive_ff);
      y_sum     = ((prod + PROD_W'(obepcm_pkg::COEF_HALF)) >>> obepcm_pkg::COEF_FRAC_BITS)
                  + x_ext - prev_ext;
      if ((&y_sum[PROD_W-1:SIG_W-1]) || !(|y_sum[PROD_W-1:SIG_W-1])) begin
         y_new = y_sum[SIG_W-1:0];
      end else if (y_sum[PROD_W-1]) begin
         y_new = {1'b1, {(SIG_W-1){1'b0}}};
      end else begin
         y_new = {1'b0, {(SIG_W-1){1'b1}}};
      end
   end

   // Scaling to 16 bits: y * 32767 is done as y * 2^15 - y.
   always_comb begin
      y_wide                 = PCM_PW'(mid_y_ff);
      round_c                = '0;
      round_c[PHASE_BITS-1]  = 1'b1;
      pcm_wide = ((y_wide <<< obepcm_pkg::PCM_SCALE_SHIFT) - y_wide + round_c) >>> PHASE_BITS;
      pcm_fits = (&pcm_wide[PCM_PW-1:PCM_W-1]) || !(|pcm_wide[PCM_PW-1:PCM_W-1]);
   end

   always_comb begin
      coef_in       = csr_ch.valid ? csr_ch.filter_coefficient : coef_ff;
      filter_out_in = pop ? y_new : filter_out_ff;
      prev_drive_in = pop ? queue_data : prev_drive_ff;

      mid_valid_in = mid_valid_ff;
      mid_y_in     = mid_y_ff;
      if (pop) begin
         mid_valid_in = 1'b1;
         mid_y_in     = y_new;
      end else if (mid_move) begin
         mid_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_pcm_in   = out_pcm_ff;
      if (out_free) begin
         out_valid_in = mid_valid_ff;
         if (mid_valid_ff) begin
            if (pcm_fits) begin
               out_pcm_in = pcm_wide[PCM_W-1:0];
            end else if (pcm_wide[PCM_PW-1]) begin
               out_pcm_in = {1'b1, {(PCM_W-1){1'b0}}};
            end else begin
               out_pcm_in = {1'b0, {(PCM_W-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff       <= obepcm_pkg::COEF_RESET;
         filter_out_ff <= '0;
         prev_drive_ff <= PREV_RESET;
         mid_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         coef_ff       <= coef_in;
         filter_out_ff <= filter_out_in;
         prev_drive_ff <= prev_drive_in;
         mid_valid_ff  <= mid_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_y_ff   <= mid_y_in;
      out_pcm_ff <= out_pcm_in;
   end

   `OBEPCM_ASSERT_NEXT(a_pop_fills_mid, clock, reset, pop, mid_valid_ff)
   `OBEPCM_ASSERT_NEXT(a_filter_holds, clock, reset, !pop, $stable(filter_out_ff))
   `OBEPCM_ASSERT_NEXT(a_mid_holds_on_stall, clock, reset,
      mid_valid_ff && !out_free, mid_valid_ff && $stable(mid_y_ff))

endmodule

// File: hw/rtl/one_bit_edge_to_pcm_dc_blocked_top.sv
// A sample tick transferred on req_ch is pushed into the queue, popped through the filter
// into mid_y_ff and then scaled into out_pcm_ff, from which it is offered on rsp_ch.
// Throughput: one item per cycle while the queue is not full; the filter's feedback
// (one 12 x 19 multiply and adds) closes through filter_out_ff alone, and the two-entry
// queue lets front and back stall apart. Level events produce no transfer on rsp_ch.
// Reset is synchronous: level low, phase, area and filter output zero, previous input -0.5,
// R = 1008/1024.
module one_bit_edge_to_pcm_dc_blocked_top #(
   parameter int PHASE_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   obepcm_req_if.sink     req_ch,
   obepcm_rsp_if.source   rsp_ch,
   obepcm_csr_if.sink     csr_ch
);

   localparam int SIG_W = PHASE_BITS + 3;

   logic                     push_valid;
   logic signed [SIG_W-1:0]  push_data;
   logic                     queue_full;
   logic                     queue_empty;
   logic signed [SIG_W-1:0]  head_data;
   logic                     pop;

   obepcm_front #(.PHASE_BITS(PHASE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   obepcm_queue #(.DATA_W(SIG_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head_data  (head_data)
   );

   obepcm_back #(.PHASE_BITS(PHASE_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_ch      (csr_ch),
      .rsp_ch      (rsp_ch),
      .queue_empty (queue_empty),
      .queue_data  (head_data),
      .pop         (pop)
   );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam longint PHASE_ONE      = 64'sd65536;
   localparam longint SIG_HIGH       = 64'sd262143;
   localparam longint SIG_LOW        = -64'sd262144;
   localparam longint PCM_HIGH       = 64'sd32767;
   localparam longint PCM_LOW        = -64'sd32768;
   localparam int     SETTLE_CYCLES  = 8;
   localparam int     HOLD_CYCLES    = 300;
   localparam int     WATCHDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset;

   obepcm_req_if req_ch ();
   obepcm_rsp_if rsp_ch ();
   obepcm_csr_if csr_ch ();

   one_bit_edge_to_pcm_dc_blocked_top #(
      .PHASE_BITS(16)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted state of the converter, kept at the block's own widths.
   logic                                  level_now;
   logic [obepcm_pkg::PHASE_IN_W-1:0]     pos_now;
   logic signed [18:0]                    area_sum;
   logic signed [18:0]                    last_x;
   logic signed [18:0]                    hp_state;
   logic [obepcm_pkg::COEF_W-1:0]         coef_reg;

   logic signed [obepcm_pkg::PCM_W-1:0]   pcm_expected_q[$];

   int errors        = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_token    = 0;

   task automatic advance_converter(input logic f,
                                    input logic [obepcm_pkg::PHASE_IN_W-1:0] ph,
                                    input logic lvl);
      longint sgn, pos_l, ph_l, area_l, r, tot, xv, yv, pv;
      sgn    = level_now ? 64'sd1 : -64'sd1;
      pos_l  = longint'(pos_now);
      ph_l   = longint'(ph);
      area_l = longint'(area_sum);
      if (f == obepcm_pkg::FUNC_EVENT) begin
         // An event that lies behind the current position adds no area.
         if (ph_l > pos_l) begin
            area_sum = 19'(area_l + (ph_l - pos_l) * sgn);
            pos_now  = ph;
         end
         level_now = lvl;
      end else begin
         r   = (coef_reg > obepcm_pkg::COEF_ONE) ? longint'(obepcm_pkg::COEF_ONE)
                                                 : longint'(coef_reg);
         tot = area_l + (PHASE_ONE - pos_l) * sgn;
         xv  = tot >>> 1;
         yv  = ((r * longint'(hp_state) + longint'(obepcm_pkg::COEF_HALF))
                >>> obepcm_pkg::COEF_FRAC_BITS) + xv - longint'(last_x);
         if (yv > SIG_HIGH) yv = SIG_HIGH;
         if (yv < SIG_LOW) yv = SIG_LOW;
         last_x   = 19'(xv);
         hp_state = 19'(yv);
         pos_now  = '0;
         area_sum = '0;
         pv = (yv * 64'sd32767 + 64'sd32768) >>> 16;
         if (pv > PCM_HIGH) pv = PCM_HIGH;
         if (pv < PCM_LOW) pv = PCM_LOW;
         pcm_expected_q.push_back(16'(pv));
      end
   endtask

   // Offers one item, at times after a random gap, and returns at the edge of its transfer.
   task automatic send_item(input logic f, input logic [obepcm_pkg::PHASE_IN_W-1:0] ph,
                            input logic lvl);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= f;
      req_ch.event_phase <= ph;
      req_ch.new_level   <= lvl;
      do @(posedge clock); while (!req_ch.ready);
      advance_converter(f, ph, lvl);
      items_sent++;
   endtask

   // The block is idle once every sample has arrived and the pipeline has drained.
   task automatic write_coefficient(input logic [obepcm_pkg::COEF_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (pcm_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid              <= 1'b1;
      csr_ch.filter_coefficient <= value;
      do @(posedge clock); while (!csr_ch.ready);
      coef_reg = value;
      csr_ch.valid <= 1'b0;
   endtask

   // One sample period: level changes at rising phases, then the tick. Now and then
   // the phases are left unsorted or the tick is replaced by a random item.
   task automatic send_period(input int max_events);
      logic [obepcm_pkg::PHASE_IN_W-1:0] marks[8];
      logic [obepcm_pkg::PHASE_IN_W-1:0] tmp;
      int n, mode;
      n    = $urandom_range(max_events, 0);
      mode = $urandom_range(99);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0:       marks[i] = '0;
            1:       marks[i] = '1;
            default: marks[i] = obepcm_pkg::PHASE_IN_W'($urandom);
         endcase
      end
      if (mode >= 15) begin
         for (int i = 0; i < n; i++)
            for (int j = 0; j + 1 < n - i; j++)
               if (marks[j] > marks[j + 1]) begin
                  tmp          = marks[j];
                  marks[j]     = marks[j + 1];
                  marks[j + 1] = tmp;
               end
      end
      for (int i = 0; i < n; i++)
         send_item(obepcm_pkg::FUNC_EVENT, marks[i], 1'($urandom));
      if (mode < 5) begin
         send_item(1'($urandom), obepcm_pkg::PHASE_IN_W'($urandom), 1'($urandom));
      end else begin
         send_item(obepcm_pkg::FUNC_TICK, obepcm_pkg::PHASE_IN_W'($urandom), 1'($urandom));
      end
   endtask

   task automatic send_random(input int budget);
      int stop_at;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) send_period(6);
   endtask

   task automatic test_directed_edges();
      // Runs at the reset value of the pole.
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'hFFFF, 1'b1);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h0000, 1'b1);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h8000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h4000, 1'b1);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h8000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'hFFFF, 1'b1);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'hFFFF, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h0001, 1'b1);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'hAAAA, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h5555, 1'b1);
      send_item(obepcm_pkg::FUNC_EVENT, 16'hFFFF, 1'b1);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'hFFFF, 1'b1);
   endtask

   task automatic test_pole_extremes();
      write_coefficient(11'd0);
      send_random(250);
      // With R = 1.0 the filter only integrates the differences.
      write_coefficient(obepcm_pkg::COEF_ONE);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h0000, 1'b1);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_EVENT, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'b0);
      send_random(250);
   endtask

   task automatic test_pole_clamped();
      write_coefficient(11'd1025);
      send_random(150);
      write_coefficient(11'd2047);
      send_random(150);
   endtask

   task automatic test_random_traffic();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_coefficient(obepcm_pkg::COEF_RESET);
      send_random(250);
      send_idle_pct = 65;
      write_coefficient(11'($urandom));
      send_random(250);
      send_idle_pct  = 0;
      recv_stall_pct = 65;
      write_coefficient(11'($urandom_range(1024, 900)));
      send_random(250);
      send_idle_pct  = 17;
      recv_stall_pct = 17;
      write_coefficient(11'($urandom));
      send_random(250);
   endtask

   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_coefficient(11'd1000);
      // The receiver holds off on its own count while ticks keep coming, so the
      // queue fills and the input stalls.
      hold_token++;
      for (int i = 0; i < 40; i++) send_item(obepcm_pkg::FUNC_TICK, 16'h0000, 1'($urandom));
      send_random(60);
   endtask

   initial begin : receiver
      int hold_left;
      int seen;
      hold_left = 0;
      seen      = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != seen) begin
            seen      = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_samples
      logic signed [obepcm_pkg::PCM_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pcm_expected_q.size() == 0) begin
            $display("%0t: pcm_sample %0d arrived with none expected", $time,
                     rsp_ch.pcm_sample);
            errors++;
         end else begin
            want = pcm_expected_q.pop_front();
            if (rsp_ch.pcm_sample !== want) begin
               $display("%0t: pcm_sample mismatch, expected %0d, actual %0d", $time,
                        want, rsp_ch.pcm_sample);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      reset                     <= 1'b1;
      req_ch.valid              <= 1'b0;
      req_ch.func               <= obepcm_pkg::FUNC_EVENT;
      req_ch.event_phase        <= '0;
      req_ch.new_level          <= 1'b0;
      csr_ch.valid              <= 1'b0;
      csr_ch.filter_coefficient <= obepcm_pkg::COEF_RESET;
      level_now = 1'b0;
      pos_now   = '0;
      area_sum  = '0;
      last_x    = -19'sd32768;
      hp_state  = '0;
      coef_reg  = obepcm_pkg::COEF_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_pole_extremes();
      test_pole_clamped();
      test_random_traffic();
      test_output_backpressure();

      req_ch.valid <= 1'b0;
      while (pcm_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pcm_expected_q.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
